@@ rtl/core/wfsa_pkg.sv @@
// ----------------------------------------------------------------------------
// wfsa_pkg
// Shared widths, table sizes and the free-table write request type.
// ----------------------------------------------------------------------------
`default_nettype none
package wfsa_pkg;

    localparam int ADDR_W    = 21;
    localparam int SIZE_W    = ADDR_W + 1;
    localparam int REQ_SLOTS = 256;
    localparam int REQ_W     = $clog2(REQ_SLOTS);
    localparam int SEG_SLOTS = REQ_SLOTS + 1;
    localparam int SEG_IDX_W = $clog2(SEG_SLOTS);

    localparam logic [SEG_IDX_W-1:0] SEG_LAST = SEG_IDX_W'(SEG_SLOTS - 1);
    localparam logic [ADDR_W-1:0]    MEM_SIZE_RST = ADDR_W'(1048576);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic                 wr_start;
        logic                 wr_stop;
        logic [SEG_IDX_W-1:0] wr_idx;
        logic [ADDR_W-1:0]    start;
        logic [ADDR_W-1:0]    stop;
        logic                 val_we;
        logic [SEG_IDX_W-1:0] val_idx;
        logic                 val_bit;
        logic                 clear_all;
    } seg_wr_t;

endpackage
`default_nettype wire

@@ rtl/core/wfsa_seg_table.sv @@
// ----------------------------------------------------------------------------
// wfsa_seg_table
// Free segment table: start/end memories with one registered read port and
// per-entry valid flops.
// ----------------------------------------------------------------------------
`default_nettype none
module wfsa_seg_table (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  wfsa_pkg::seg_wr_t          wr,
    input  wire  [wfsa_pkg::SEG_IDX_W-1:0]   rd_idx,
    output logic [wfsa_pkg::ADDR_W-1:0]      rd_start,
    output logic [wfsa_pkg::ADDR_W-1:0]      rd_stop,
    output logic                             rd_valid
);
    import wfsa_pkg::*;

    logic [ADDR_W-1:0] start_mem [0:SEG_SLOTS-1];
    logic [ADDR_W-1:0] stop_mem  [0:SEG_SLOTS-1];
    logic [SEG_SLOTS-1:0] valid_reg;
    logic [SEG_SLOTS-1:0] valid_next;

    always_ff @(posedge aclk) begin
        if (wr.wr_start) begin
            start_mem[wr.wr_idx] <= wr.start;
        end
        if (wr.wr_stop) begin
            stop_mem[wr.wr_idx] <= wr.stop;
        end
        rd_start <= start_mem[rd_idx];
        rd_stop  <= stop_mem[rd_idx];
    end

    always_comb begin
        valid_next = wr.clear_all ? '0 : valid_reg;
        if (wr.val_we) begin
            valid_next[wr.val_idx] = wr.val_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rd_valid  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            rd_valid  <= valid_reg[rd_idx];
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/worst_fit_segment_allocator_core.sv @@
// ----------------------------------------------------------------------------
// worst_fit_segment_allocator_core
// Worst-fit cell allocator with neighbour coalescing on free.
// ----------------------------------------------------------------------------
// Requests arrive on s_: tuser carries op (0 allocate, 1 free), tdata carries
// amount and req_number. An allocate gives one response on m_: tuser is ok,
// tdata the start cell (0 on failure). A free gives no response.
// Every nonzero allocate and every free of a held number scans all 257
// free-table entries through one registered read port, one entry per cycle;
// s_tready is low until the allocate is answered or the free finishes.
// An allocate of zero cells skips the scan and is answered as a failure; a
// free of an unheld number ends after the block-record lookup, with no scan.
// The response sits in an output register; a stalled receiver holds the next
// allocate in its final state until the register is taken.
// cfg_w* writes memory_size while idle; the free table is then rebuilt as one
// segment in ST_INIT. After reset the block builds the table 1..1048576 in
// ST_INIT before raising s_tready. Block records survive a memory_size
// write.
// ----------------------------------------------------------------------------
`default_nettype none
module worst_fit_segment_allocator_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // amount[20:0], req_number[28:21], zero pad
    input  wire  [0:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // start_cell[20:0], zero pad
    output logic [0:0]  m_tuser,   // ok
    input  wire         cfg_wvalid,
    output logic        cfg_wready,
    input  wire  [20:0] cfg_wdata  // memory_size
);
    import wfsa_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_LOOK, ST_SCAN, ST_DRAIN, ST_UPD, ST_RESP
    } state_t;

    state_t state_reg;

    logic [ADDR_W-1:0]    ms_reg;
    logic                 op_reg;
    logic [ADDR_W-1:0]    amt_reg;
    logic [REQ_W-1:0]     num_reg;
    logic [SEG_IDX_W-1:0] cnt_reg;
    logic                 pact_reg;
    logic                 found_reg;
    logic [SEG_IDX_W-1:0] best_idx_reg;
    logic [SIZE_W-1:0]    best_size_reg;
    logic [ADDR_W-1:0]    best_start_reg;
    logic                 lf_reg, rf_reg, if_reg;
    logic [SEG_IDX_W-1:0] l_idx_reg, r_idx_reg, ins_idx_reg;
    logic [ADDR_W-1:0]    r_end_reg;
    logic                 ok_reg;
    logic [ADDR_W-1:0]    res_start_reg;
    logic                 m_tvalid_reg;
    logic                 m_ok_reg;
    logic [ADDR_W-1:0]    m_start_reg;
    logic [REQ_SLOTS-1:0] blk_valid_reg;

    logic [ADDR_W-1:0] blk_start_mem [0:REQ_SLOTS-1];
    logic [ADDR_W-1:0] blk_stop_mem  [0:REQ_SLOTS-1];
    logic [ADDR_W-1:0] bs_reg, be_reg;

    logic              s_acc;
    logic [ADDR_W-1:0] in_amt;
    logic [REQ_W-1:0]  in_num;
    logic              blk_we;
    logic [ADDR_W-1:0] blk_stop_w;

    seg_wr_t           seg_wr;
    logic [ADDR_W-1:0] rd_start, rd_stop;
    logic              rd_valid;

    logic [SIZE_W-1:0] size;
    logic              fits, better, left_hit, right_hit, ins_hit;
    logic              out_free;

    assign in_amt     = s_tdata[ADDR_W-1:0];
    assign in_num     = s_tdata[ADDR_W+REQ_W-1:ADDR_W];
    assign cfg_wready = (state_reg == ST_IDLE);
    assign s_tready   = (state_reg == ST_IDLE) && !cfg_wvalid;
    assign s_acc      = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_ok_reg;
    assign m_tdata  = {3'b000, m_start_reg};

    wfsa_seg_table u_seg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (seg_wr),
        .rd_idx   (cnt_reg),
        .rd_start (rd_start),
        .rd_stop  (rd_stop),
        .rd_valid (rd_valid)
    );

    // scan evaluation on the entry read last cycle
    assign size   = {1'b0, rd_stop} - {1'b0, rd_start} + SIZE_W'(1);
    assign fits   = rd_valid && (rd_stop >= rd_start) && (size >= {1'b0, amt_reg});
    assign better = !found_reg || (size > best_size_reg) ||
                    ((size == best_size_reg) && (rd_start < best_start_reg));
    assign left_hit  = rd_valid && !lf_reg &&
                       (({1'b0, rd_stop} + SIZE_W'(1)) == {1'b0, bs_reg});
    assign right_hit = rd_valid && !left_hit && !rf_reg &&
                       ({1'b0, rd_start} == ({1'b0, be_reg} + SIZE_W'(1)));
    assign ins_hit   = !rd_valid && !if_reg;

    assign blk_we     = (state_reg == ST_UPD) && (op_reg == OP_ALLOC) && found_reg;
    assign blk_stop_w = best_start_reg + amt_reg - ADDR_W'(1);

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            bs_reg <= blk_start_mem[in_num];
            be_reg <= blk_stop_mem[in_num];
        end
        if (blk_we) begin
            blk_start_mem[num_reg] <= best_start_reg;
            blk_stop_mem[num_reg]  <= blk_stop_w;
        end
    end

    always_comb begin
        seg_wr = '0;
        unique case (state_reg)
            ST_INIT: begin
                seg_wr.wr_start  = 1'b1;
                seg_wr.wr_stop   = 1'b1;
                seg_wr.start     = ADDR_W'(1);
                seg_wr.stop      = ms_reg;
                seg_wr.clear_all = 1'b1;
                seg_wr.val_we    = 1'b1;
                seg_wr.val_bit   = (ms_reg != '0);
            end
            ST_UPD: begin
                if (op_reg == OP_ALLOC) begin
                    if (found_reg) begin
                        seg_wr.wr_start = 1'b1;
                        seg_wr.wr_idx   = best_idx_reg;
                        seg_wr.start    = best_start_reg + amt_reg;
                        seg_wr.val_we   = ({1'b0, amt_reg} == best_size_reg);
                        seg_wr.val_idx  = best_idx_reg;
                    end
                end else if (lf_reg && rf_reg) begin
                    seg_wr.wr_stop = 1'b1;
                    seg_wr.wr_idx  = l_idx_reg;
                    seg_wr.stop    = r_end_reg;
                    seg_wr.val_we  = 1'b1;
                    seg_wr.val_idx = r_idx_reg;
                end else if (lf_reg) begin
                    seg_wr.wr_stop = 1'b1;
                    seg_wr.wr_idx  = l_idx_reg;
                    seg_wr.stop    = be_reg;
                end else if (rf_reg) begin
                    seg_wr.wr_start = 1'b1;
                    seg_wr.wr_idx   = r_idx_reg;
                    seg_wr.start    = bs_reg;
                end else if (if_reg) begin
                    seg_wr.wr_start = 1'b1;
                    seg_wr.wr_stop  = 1'b1;
                    seg_wr.wr_idx   = ins_idx_reg;
                    seg_wr.start    = bs_reg;
                    seg_wr.stop     = be_reg;
                    seg_wr.val_we   = 1'b1;
                    seg_wr.val_idx  = ins_idx_reg;
                    seg_wr.val_bit  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            ms_reg        <= MEM_SIZE_RST;
            m_tvalid_reg  <= 1'b0;
            pact_reg      <= 1'b0;
            blk_valid_reg <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_RESP)) begin
                m_tvalid_reg <= 1'b0;
            end
            if (pact_reg) begin
                if (op_reg == OP_ALLOC) begin
                    if (fits && better) begin
                        found_reg      <= 1'b1;
                        best_idx_reg   <= cnt_reg - SEG_IDX_W'(1);
                        best_size_reg  <= size;
                        best_start_reg <= rd_start;
                    end
                end else begin
                    if (left_hit) begin
                        lf_reg    <= 1'b1;
                        l_idx_reg <= cnt_reg - SEG_IDX_W'(1);
                    end
                    if (right_hit) begin
                        rf_reg    <= 1'b1;
                        r_idx_reg <= cnt_reg - SEG_IDX_W'(1);
                        r_end_reg <= rd_stop;
                    end
                    if (ins_hit) begin
                        if_reg      <= 1'b1;
                        ins_idx_reg <= cnt_reg - SEG_IDX_W'(1);
                    end
                end
            end
            unique case (state_reg)
                ST_INIT: begin
                    state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                    lf_reg    <= 1'b0;
                    rf_reg    <= 1'b0;
                    if_reg    <= 1'b0;
                    if (cfg_wvalid) begin
                        ms_reg    <= cfg_wdata;
                        state_reg <= ST_INIT;
                    end else if (s_acc) begin
                        op_reg  <= s_tuser[0];
                        amt_reg <= in_amt;
                        num_reg <= in_num;
                        if (s_tuser[0] == OP_FREE) begin
                            state_reg <= ST_LOOK;
                        end else if (in_amt == '0) begin
                            ok_reg        <= 1'b0;
                            res_start_reg <= '0;
                            state_reg     <= ST_RESP;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_LOOK: begin
                    state_reg <= blk_valid_reg[num_reg] ? ST_SCAN : ST_IDLE;
                end
                ST_SCAN: begin
                    pact_reg <= 1'b1;
                    cnt_reg  <= cnt_reg + SEG_IDX_W'(1);
                    if (cnt_reg == SEG_LAST) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    pact_reg  <= 1'b0;
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    if (op_reg == OP_ALLOC) begin
                        ok_reg        <= found_reg;
                        res_start_reg <= found_reg ? best_start_reg : '0;
                        if (found_reg) begin
                            blk_valid_reg[num_reg] <= 1'b1;
                        end
                        state_reg <= ST_RESP;
                    end else begin
                        blk_valid_reg[num_reg] <= 1'b0;
                        state_reg              <= ST_IDLE;
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_ok_reg     <= ok_reg;
                        m_start_reg  <= res_start_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_INIT;
                end
            endcase
        end
    end

    // the last SCAN cycle (and not the ST_DRAIN cycle) must leave cnt_reg one
    // past the final entry for the index arithmetic above
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (!s_tready && !cfg_wready))
        else $error("request taken while busy");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("failed allocate with non-zero start");

    a_ok_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata != '0))
        else $error("successful allocate at cell zero");

    a_reset_init: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !s_tready)
        else $error("ready before free table built");

    a_scan_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> (cnt_reg == SEG_IDX_W'(SEG_SLOTS)))
        else $error("scan did not cover every entry");

endmodule
`default_nettype wire
